// ----- hdl/lphm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg
// shared types and constants of the linear probing hash map unit
// ----------------------------------------------------------------------------
package lphm_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 5;
	localparam int TS_W    = 5;
	localparam int OP_W    = 2;
	localparam int ST_W    = 3;
	// magnitude bits consumed per divider cycle
	localparam int DIV_STEP = 8;
	localparam int DIV_CYC  = KEY_W / DIV_STEP;

	localparam logic [TS_W-1:0] TS_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef enum logic [ST_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_FOUND    = 3'd3,
		ST_MISSING  = 3'd4,
		ST_REMOVED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

endpackage

// ----- hdl/lphm_home_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_home_div
// iterative remainder unit: magnitude mod table size, eight bits per cycle
// ----------------------------------------------------------------------------
module lphm_home_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lphm_pkg::KEY_W-1:0]    mag,
	input  logic [lphm_pkg::TS_W-1:0]     divisor,
	output logic                          done,
	output logic [lphm_pkg::TS_W-1:0]     rem
);

	localparam int CW = $clog2(lphm_pkg::DIV_CYC);

	logic [lphm_pkg::KEY_W-1:0] mag_q;
	logic [lphm_pkg::TS_W-1:0]  rem_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lphm_pkg::TS_W-1:0]  rem_next;

	// restoring steps over the top byte of the remaining magnitude
	always_comb begin
		logic [lphm_pkg::TS_W:0] t;
		rem_next = rem_q;
		for (int i = 0; i < lphm_pkg::DIV_STEP; i++) begin
			t = {rem_next, mag_q[lphm_pkg::KEY_W-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_next = t[lphm_pkg::TS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(lphm_pkg::DIV_CYC - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(lphm_pkg::DIV_CYC - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_q << lphm_pkg::DIV_STEP;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/lphm_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_slot_ram
// key/value slot memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module lphm_slot_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  lphm_pkg::slot_t       wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output lphm_pkg::slot_t       rd_data
);

	lphm_pkg::slot_t mem [DEPTH];
	lphm_pkg::slot_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- hdl/linear_probe_hash_map_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_unit
// open addressing key/value table with linear probing and lazy deletion
// ----------------------------------------------------------------------------
// the home slot is the key magnitude mod the effective table size, taken by the divider
//   a byte at a time; the walk then reads one slot per cycle from the slot memory,
//   probing from one slot up to the table size
// refused inserts and unused opcodes skip the divider and the walk and go straight to finish
// one request in flight; the next is accepted once the result is registered
// reset: all slots never used, no tombstones, count zero, table size 16
module linear_probe_hash_map_unit #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,     // table_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,       // opcode[1:0], key[33:2], value_in[65:34], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata        // status[2:0], value_out[34:3], live_count[39:35]
);

	// slots beyond the largest table size a 5-bit register can select are never used
	localparam int DEPTH = (SLOTS < 31) ? SLOTS : 31;
	localparam int IW    = $clog2(DEPTH);
	localparam logic [lphm_pkg::TS_W-1:0] DEPTH_C = lphm_pkg::TS_W'(DEPTH);

	lphm_pkg::state_t state_q, state_next;

	logic [lphm_pkg::TS_W-1:0]  ts_q;
	logic [lphm_pkg::TS_W-1:0]  n;
	logic [lphm_pkg::OP_W-1:0]  op_q;
	logic [lphm_pkg::KEY_W-1:0] key_q;
	logic [lphm_pkg::VAL_W-1:0] val_q;
	logic                       skip_q;
	lphm_pkg::status_t          skip_st_q;
	logic [IW-1:0]              idx_q;
	logic [lphm_pkg::TS_W-1:0]  steps_q;
	logic                       have_match_q;
	logic                       have_free_q;
	logic [IW-1:0]              match_q;
	logic [IW-1:0]              free_q;
	logic [lphm_pkg::VAL_W-1:0] hit_val_q;
	logic [DEPTH-1:0]           never_used_q;
	logic [DEPTH-1:0]           tomb_q;
	logic [lphm_pkg::CNT_W-1:0] count_q;

	logic                       out_valid_q;
	lphm_pkg::status_t          out_status_q;
	logic [lphm_pkg::VAL_W-1:0] out_value_q;
	logic [lphm_pkg::CNT_W-1:0] out_count_q;

	logic [lphm_pkg::OP_W-1:0]  in_op;
	logic [lphm_pkg::KEY_W-1:0] in_key;
	logic [lphm_pkg::VAL_W-1:0] in_val;
	logic [lphm_pkg::KEY_W-1:0] in_mag;
	logic                       accept;
	logic                       in_full;
	logic                       in_skip;

	logic                       div_start;
	logic                       div_done;
	logic [lphm_pkg::TS_W-1:0]  div_rem;

	logic                       rd_en;
	logic [IW-1:0]              rd_addr;
	lphm_pkg::slot_t            rd_slot;
	logic                       wr_en;
	logic [IW-1:0]              wr_addr;
	lphm_pkg::slot_t            wr_slot;

	logic                       nu;
	logic                       tb;
	logic                       hit;
	logic                       probe_end;
	logic [IW-1:0]              idx_inc;

	logic                       can_out;
	logic                       fin;
	lphm_pkg::status_t          fin_status;
	logic [lphm_pkg::VAL_W-1:0] fin_value;
	logic [lphm_pkg::CNT_W-1:0] fin_count;
	logic                       ins_new;
	logic                       rem_hit;

	// effective table size
	always_comb begin
		if (ts_q == '0) begin
			n = lphm_pkg::TS_W'(1);
		end else if (ts_q > DEPTH_C) begin
			n = DEPTH_C;
		end else begin
			n = ts_q;
		end
	end

	assign in_op  = s_tdata[1:0];
	assign in_key = s_tdata[33:2];
	assign in_val = s_tdata[65:34];
	assign in_mag = in_key[lphm_pkg::KEY_W-1] ? (lphm_pkg::KEY_W'(0) - in_key) : in_key;

	assign s_tready = (state_q == lphm_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	// refused once 10 * count >= 7 * size
	assign in_full  = (in_op == lphm_pkg::OP_INSERT) &&
		((9'(count_q) * 9'd10) >= (9'(n) * 9'd7));
	assign in_skip  = in_full || !((in_op == lphm_pkg::OP_INSERT) ||
		(in_op == lphm_pkg::OP_SEARCH) || (in_op == lphm_pkg::OP_REMOVE));
	assign div_start = accept && !in_skip;

	lphm_home_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.mag     (in_mag),
		.divisor (n),
		.done    (div_done),
		.rem     (div_rem)
	);

	// probe of the slot whose data arrives this cycle
	assign nu        = never_used_q[idx_q];
	assign tb        = tomb_q[idx_q];
	assign hit       = !nu && !tb && (rd_slot.key == key_q);
	assign probe_end = nu || hit || (steps_q == (n - lphm_pkg::TS_W'(1)));
	assign idx_inc   = ((lphm_pkg::TS_W'(idx_q) + lphm_pkg::TS_W'(1)) == n) ?
		'0 : (idx_q + IW'(1));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_inc;
		if (state_q == lphm_pkg::S_HASH && div_done) begin
			rd_en   = 1'b1;
			rd_addr = div_rem[IW-1:0];
		end else if (state_q == lphm_pkg::S_PROBE && !probe_end) begin
			rd_en   = 1'b1;
		end
	end

	lphm_slot_ram #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_slot),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_slot)
	);

	// result and table update for the finished request
	assign can_out = !out_valid_q || m_tready;
	assign fin     = (state_q == lphm_pkg::S_FINISH) && can_out;

	always_comb begin
		fin_status = lphm_pkg::ST_MISSING;
		fin_value  = '0;
		fin_count  = count_q;
		ins_new    = 1'b0;
		rem_hit    = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = have_match_q ? match_q : free_q;
		wr_slot.key   = key_q;
		wr_slot.value = val_q;
		if (skip_q) begin
			fin_status = skip_st_q;
		end else begin
			case (op_q)
				lphm_pkg::OP_INSERT: begin
					if (have_match_q) begin
						fin_status = lphm_pkg::ST_UPDATED;
						wr_en      = fin;
					end else if (have_free_q) begin
						fin_status = lphm_pkg::ST_INSERTED;
						ins_new    = 1'b1;
						wr_en      = fin;
						fin_count  = count_q + 1'b1;
					end else begin
						fin_status = lphm_pkg::ST_FULL;
					end
				end
				lphm_pkg::OP_SEARCH: begin
					if (have_match_q) begin
						fin_status = lphm_pkg::ST_FOUND;
						fin_value  = hit_val_q;
					end
				end
				lphm_pkg::OP_REMOVE: begin
					if (have_match_q) begin
						fin_status = lphm_pkg::ST_REMOVED;
						rem_hit    = 1'b1;
						if (count_q != '0) begin
							fin_count = count_q - 1'b1;
						end
					end
				end
				default: begin
					fin_status = lphm_pkg::ST_MISSING;
				end
			endcase
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			lphm_pkg::S_IDLE: begin
				if (accept) begin
					state_next = in_skip ? lphm_pkg::S_FINISH : lphm_pkg::S_HASH;
				end
			end
			lphm_pkg::S_HASH: begin
				if (div_done) begin
					state_next = lphm_pkg::S_PROBE;
				end
			end
			lphm_pkg::S_PROBE: begin
				if (probe_end) begin
					state_next = lphm_pkg::S_FINISH;
				end
			end
			lphm_pkg::S_FINISH: begin
				if (can_out) begin
					state_next = lphm_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = lphm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lphm_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q         <= lphm_pkg::TS_RESET;
			never_used_q <= '1;
			tomb_q       <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			have_match_q <= 1'b0;
			have_free_q  <= 1'b0;
			skip_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				ts_q <= cfg_wdata;
			end
			if (accept) begin
				skip_q       <= in_skip;
				have_match_q <= 1'b0;
				have_free_q  <= 1'b0;
			end
			if (state_q == lphm_pkg::S_PROBE) begin
				if ((nu || tb) && !have_free_q) begin
					have_free_q <= 1'b1;
				end
				if (hit) begin
					have_match_q <= 1'b1;
				end
			end
			if (m_tready && !fin) begin
				out_valid_q <= 1'b0;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
				count_q     <= fin_count;
				if (ins_new) begin
					never_used_q[free_q] <= 1'b0;
					tomb_q[free_q]       <= 1'b0;
				end
				if (rem_hit) begin
					tomb_q[match_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= in_op;
			key_q     <= in_key;
			val_q     <= in_val;
			skip_st_q <= in_full ? lphm_pkg::ST_FULL : lphm_pkg::ST_MISSING;
		end
		if (state_q == lphm_pkg::S_HASH && div_done) begin
			idx_q   <= div_rem[IW-1:0];
			steps_q <= '0;
		end
		if (state_q == lphm_pkg::S_PROBE) begin
			if ((nu || tb) && !have_free_q) begin
				free_q <= idx_q;
			end
			if (hit) begin
				match_q   <= idx_q;
				hit_val_q <= rd_slot.value;
			end else if (!probe_end) begin
				idx_q   <= idx_inc;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (fin) begin
			out_status_q <= fin_status;
			out_value_q  <= fin_value;
			out_count_q  <= fin_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_value_q, out_status_q};

endmodule
